// ===== rtl/lruc_pkg.sv =====
// ============================================================================
// lruc_pkg: shared types and constants for the LRU key-value cache
// Entry count, field widths, request/result structs and register map.
// ============================================================================
package lruc_pkg;

    // Entry store geometry
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int RANK_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Payload widths
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    // Word address of the capacity register (paddr[2])
    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Value returned by a get that misses
    localparam logic [DATA_W-1:0] READ_MISS = {DATA_W{1'b1}};

    // Request codes
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef struct packed {
        logic              action;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
    } res_t;

endpackage

// ===== rtl/lruc_core.sv =====
// ============================================================================
// lruc_core: entry store with combinational lookup and registered update
// Holds keys, data, valid bits and recency ranks; matches all entries in
// parallel and commits the get/put update when the request advances.
// ============================================================================
module lruc_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  lruc_pkg::req_t            req,
    input  logic [lruc_pkg::CAP_W-1:0] cap_raw,
    output lruc_pkg::res_t            res
);

    logic [lruc_pkg::MAX_ENTRIES-1:0] valid_reg;
    logic [lruc_pkg::MAX_ENTRIES-1:0] valid_next;
    logic [lruc_pkg::KEY_W-1:0]       key_reg   [lruc_pkg::MAX_ENTRIES];
    logic [lruc_pkg::KEY_W-1:0]       key_next  [lruc_pkg::MAX_ENTRIES];
    logic [lruc_pkg::DATA_W-1:0]      data_reg  [lruc_pkg::MAX_ENTRIES];
    logic [lruc_pkg::DATA_W-1:0]      data_next [lruc_pkg::MAX_ENTRIES];
    logic [lruc_pkg::RANK_W-1:0]      rank_reg  [lruc_pkg::MAX_ENTRIES];
    logic [lruc_pkg::RANK_W-1:0]      rank_next [lruc_pkg::MAX_ENTRIES];

    logic [lruc_pkg::MAX_ENTRIES-1:0] match;
    logic [lruc_pkg::MAX_ENTRIES-1:0] evict;
    logic [lruc_pkg::MAX_ENTRIES-1:0] kept;
    logic                             found;
    logic [lruc_pkg::IDX_W-1:0]       found_idx;
    logic [lruc_pkg::RANK_W-1:0]      found_rank;
    logic                             slot_ok;
    logic [lruc_pkg::IDX_W-1:0]       slot_idx;
    logic [lruc_pkg::CNT_W-1:0]       count;
    logic [lruc_pkg::CAP_W-1:0]       cap;
    logic                             full;

    // Clamp capacity into 1 .. MAX_ENTRIES
    always_comb
    begin
        cap = cap_raw;
        if (cap_raw == '0)
        begin
            cap = lruc_pkg::CAP_W'(1);
        end
        else if (cap_raw > lruc_pkg::CAP_W'(lruc_pkg::MAX_ENTRIES))
        begin
            cap = lruc_pkg::CAP_W'(lruc_pkg::MAX_ENTRIES);
        end
    end

    // Parallel match; highest matching entry wins
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        count     = '0;
        for (int i = 0; i < lruc_pkg::MAX_ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == req.key);
            if (match[i])
            begin
                found     = 1'b1;
                found_idx = lruc_pkg::IDX_W'(i);
            end
            count = count + lruc_pkg::CNT_W'(valid_reg[i]);
        end
        found_rank = rank_reg[found_idx];
    end

    // Eviction set and lowest free slot for an insert
    always_comb
    begin
        full     = (lruc_pkg::CAP_W'(count) >= cap);
        slot_ok  = 1'b0;
        slot_idx = '0;
        for (int i = 0; i < lruc_pkg::MAX_ENTRIES; i++)
        begin
            evict[i] = full && valid_reg[i] &&
                       (lruc_pkg::CAP_W'(rank_reg[i]) >= (cap - lruc_pkg::CAP_W'(1)));
            kept[i]  = valid_reg[i] && !evict[i];
        end
        for (int i = lruc_pkg::MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (!kept[i])
            begin
                slot_ok  = 1'b1;
                slot_idx = lruc_pkg::IDX_W'(i);
            end
        end
    end

    // Next state of the store
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < lruc_pkg::MAX_ENTRIES; i++)
        begin
            key_next[i]  = key_reg[i];
            data_next[i] = data_reg[i];
            rank_next[i] = rank_reg[i];
        end
        if (fire)
        begin
            if (found)
            begin
                // Promote: more recent entries age by one
                for (int i = 0; i < lruc_pkg::MAX_ENTRIES; i++)
                begin
                    if (valid_reg[i] && (rank_reg[i] < found_rank))
                    begin
                        rank_next[i] = rank_reg[i] + lruc_pkg::RANK_W'(1);
                    end
                end
                rank_next[found_idx] = '0;
                if (req.action == lruc_pkg::ACT_PUT)
                begin
                    data_next[found_idx] = req.value;
                end
            end
            else if (req.action == lruc_pkg::ACT_PUT)
            begin
                valid_next = kept;
                for (int i = 0; i < lruc_pkg::MAX_ENTRIES; i++)
                begin
                    if (kept[i])
                    begin
                        rank_next[i] = rank_reg[i] + lruc_pkg::RANK_W'(1);
                    end
                end
                if (slot_ok)
                begin
                    valid_next[slot_idx] = 1'b1;
                    key_next[slot_idx]   = req.key;
                    data_next[slot_idx]  = req.value;
                    rank_next[slot_idx]  = '0;
                end
            end
        end
    end

    always_comb
    begin
        res.hit = found;
        if (req.action == lruc_pkg::ACT_PUT)
        begin
            res.read_value = req.value;
        end
        else if (found)
        begin
            res.read_value = data_reg[found_idx];
        end
        else
        begin
            res.read_value = lruc_pkg::READ_MISS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < lruc_pkg::MAX_ENTRIES; i++)
        begin
            key_reg[i]  <= key_next[i];
            data_reg[i] <= data_next[i];
            rank_reg[i] <= rank_next[i];
        end
    end

endmodule

// ===== rtl/lru_key_value_cache_top.sv =====
// ============================================================================
// lru_key_value_cache_top: fully associative key-value cache, LRU replacement
// Get/put requests against a 16-entry store with a programmable capacity.
// ============================================================================
// A request (action, lookup_key, write_value) is captured in an input
// register; when it advances, all 16 entries are matched in parallel, the
// recency ranks and the store are updated, and the result (hit, read_value)
// is written to the output register, which raises out_valid. One request
// is accepted every cycle while the result channel drains: the parallel
// match and rank update in the core are combinational and set that rate,
// and the request behind sees the store as updated by the one ahead. A get
// that hits returns the stored value and makes the entry most recent; a get
// that misses returns all ones. A put returns write_value; on a present key
// it overwrites and promotes, on an absent key it inserts into the lowest
// free entry, first dropping the least recent entries once the occupancy
// has reached the capacity. Capacity lives at byte address 0
// (entries_in_use, 5 bits, reset 16); 0 acts as 1 and values above 16 act
// as 16. Write it only while no request is in flight.
module lru_key_value_cache_top (
    input  logic                             clk,
    input  logic                             rst_n,

    // Request channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic signed [lruc_pkg::KEY_W-1:0]  lookup_key,
    input  logic signed [lruc_pkg::DATA_W-1:0] write_value,

    // Result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             hit,
    output logic signed [lruc_pkg::DATA_W-1:0] read_value,

    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lruc_pkg::PADDR_W-1:0]     paddr,
    input  logic [lruc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lruc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    lruc_pkg::req_t                 req_reg;
    lruc_pkg::req_t                 req_next;
    logic                           req_valid_reg;
    logic                           req_valid_next;
    lruc_pkg::res_t                 res;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           hit_reg;
    logic                           hit_next;
    logic [lruc_pkg::DATA_W-1:0]    read_value_reg;
    logic [lruc_pkg::DATA_W-1:0]    read_value_next;
    logic [lruc_pkg::CAP_W-1:0]     cap_reg;
    logic [lruc_pkg::CAP_W-1:0]     cap_next;

    logic                           out_free;
    logic                           advance;
    logic                           accept_in;
    logic                           cfg_write;

    // Advance the held request when the result register is empty or drains
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = req_valid_reg && out_free;
    assign in_stall  = req_valid_reg && !out_free;
    assign accept_in = in_valid && !in_stall;

    always_comb
    begin
        req_valid_next = accept_in || (req_valid_reg && !advance);
        req_next       = req_reg;
        if (accept_in)
        begin
            req_next.action = action;
            req_next.key    = lookup_key;
            req_next.value  = write_value;
        end
    end

    // Match and update happen in the core as the request advances
    lruc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .req     (req_reg),
        .cap_raw (cap_reg),
        .res     (res)
    );

    // Load the result register on advance; hold it while stalled
    always_comb
    begin
        out_valid_next  = advance || (out_valid_reg && out_stall);
        hit_next        = hit_reg;
        read_value_next = read_value_reg;
        if (advance)
        begin
            hit_next        = res.hit;
            read_value_next = res.read_value;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

    // Configuration: single capacity register, word-decoded on paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_write && (paddr[2] == lruc_pkg::REG_ENTRIES_IN_USE))
        begin
            cap_next = pwdata[lruc_pkg::CAP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == lruc_pkg::REG_ENTRIES_IN_USE)
        begin
            prdata = lruc_pkg::APB_DATA_W'(cap_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= lruc_pkg::CAP_RESET;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
            cap_reg       <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        hit_reg        <= hit_next;
        read_value_reg <= read_value_next;
    end

endmodule
